/* hw/rtl/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg
// Shared sizes, request and status codes and the controller command bundle
// of the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int KIND_W   = 4;
  localparam int POS_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 3;

  // stream payload widths
  localparam int IN_DATA_W  = POS_W + WORD_W;
  localparam int OUT_DATA_W = STAT_W + WORD_W + CNT_W;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    K_INS_TAIL   = 4'd0,
    K_INS_HEAD   = 4'd1,
    K_INS_POS    = 4'd2,
    K_INS_SORTED = 4'd3,
    K_READ       = 4'd4,
    K_DEL_HEAD   = 4'd5,
    K_DEL_TAIL   = 4'd6,
    K_DEL_POS    = 4'd7,
    K_DEL_VALUE  = 4'd8,
    K_MIDDLE     = 4'd9
  } kind_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // read value reported on any request that does not read an element
  localparam logic [WORD_W-1:0] NO_VALUE = '1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted request
    logic commit;  // apply the request to the cell row and capture the result
  } cmd_t;

endpackage

/* hw/rtl/olist_ctrl.sv */
// ----------------------------------------------------------------------------
// olist_ctrl
// Request sequencer: accepts one request, runs it through the cell row once
// the result register is free, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module olist_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output olist_pkg::cmd_t cmd
);
  import olist_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new result this cycle
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // sequence one request at a time
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.load      = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/olist_cells.sv */
// ----------------------------------------------------------------------------
// olist_cells
// Datapath: request register, a row of list cells that compare against the
// request value in parallel and shift by one toward the tail or the head,
// the element count and the result register.
// ----------------------------------------------------------------------------
module olist_cells (
  input  logic                                clk,
  input  logic                                rst_n,
  input  olist_pkg::cmd_t                     cmd,
  input  logic [olist_pkg::KIND_W-1:0]        in_kind,
  input  logic [olist_pkg::POS_W-1:0]         in_position,
  input  logic signed [olist_pkg::WORD_W-1:0] in_value,
  output logic [olist_pkg::STAT_W-1:0]        res_status,
  output logic signed [olist_pkg::WORD_W-1:0] res_read_value,
  output logic [olist_pkg::CNT_W-1:0]         res_count
);
  import olist_pkg::*;

  // request register
  logic [KIND_W-1:0]        req_kind_r;
  logic [POS_W-1:0]         req_pos_r;
  logic signed [WORD_W-1:0] req_val_r;

  // cell row and occupancy
  logic signed [WORD_W-1:0] cell_r   [CAPACITY];
  logic signed [WORD_W-1:0] cell_nxt [CAPACITY];
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  // result register
  logic [STAT_W-1:0]        status_r;
  logic signed [WORD_W-1:0] rd_r;
  logic [CNT_W-1:0]         count_r;

  // compare results and decisions
  logic [CAPACITY-1:0] ge_vec, eq_vec;
  logic [CNT_W-1:0]    ge_idx, eq_idx;
  logic                eq_found;
  logic                full, empty;
  logic                pos_gt_cnt, pos_ge_cnt;
  logic                do_ins, do_del, do_rd;
  logic [CNT_W-1:0]    tgt;
  logic [IDX_W-1:0]    rd_idx;
  logic [STAT_W-1:0]   st;
  logic signed [WORD_W-1:0] rd_word;

  // capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r <= in_kind;
      req_pos_r  <= in_position;
      req_val_r  <= in_value;
    end
  end

  // compare every occupied cell against the request value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_vec[i] = (CNT_W'(i) < cnt_r) && (cell_r[i] >= req_val_r);
      eq_vec[i] = (CNT_W'(i) < cnt_r) && (cell_r[i] == req_val_r);
    end
  end

  // first not-smaller and first equal cell; a miss points past the tail
  always_comb begin
    ge_idx   = cnt_r;
    eq_idx   = cnt_r;
    eq_found = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (ge_vec[i]) ge_idx = CNT_W'(i);
      if (eq_vec[i]) begin
        eq_idx   = CNT_W'(i);
        eq_found = 1'b1;
      end
    end
  end

  assign full       = (cnt_r == CNT_W'(CAPACITY));
  assign empty      = (cnt_r == '0);
  assign pos_gt_cnt = (req_pos_r > POS_W'(cnt_r));
  assign pos_ge_cnt = (req_pos_r >= POS_W'(cnt_r));

  // decode the request into one insert, delete or read
  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    do_rd  = 1'b0;
    tgt    = '0;
    rd_idx = '0;
    st     = ST_OK;
    case (kind_t'(req_kind_r))
      K_INS_TAIL: begin
        if (full) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          tgt    = cnt_r;
        end
      end
      K_INS_HEAD: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      K_INS_POS: begin
        if (pos_gt_cnt) st = ST_BADPOS;
        else if (full) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          tgt    = CNT_W'(req_pos_r);
        end
      end
      K_INS_SORTED: begin
        if (full) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          tgt    = ge_idx;
        end
      end
      K_READ: begin
        if (pos_ge_cnt) st = ST_BADPOS;
        else begin
          do_rd  = 1'b1;
          rd_idx = req_pos_r[IDX_W-1:0];
        end
      end
      K_DEL_HEAD: begin
        if (empty) st = ST_EMPTY;
        else do_del = 1'b1;
      end
      K_DEL_TAIL: begin
        if (empty) st = ST_EMPTY;
        else begin
          do_del = 1'b1;
          tgt    = cnt_r - CNT_W'(1);
        end
      end
      K_DEL_POS: begin
        if (empty) st = ST_EMPTY;
        else if (pos_ge_cnt) st = ST_BADPOS;
        else begin
          do_del = 1'b1;
          tgt    = CNT_W'(req_pos_r);
        end
      end
      K_DEL_VALUE: begin
        if (empty) st = ST_EMPTY;
        else if (!eq_found) st = ST_NOTFOUND;
        else begin
          do_del = 1'b1;
          tgt    = eq_idx;
        end
      end
      K_MIDDLE: begin
        if (empty) st = ST_EMPTY;
        else begin
          do_rd  = 1'b1;
          rd_idx = IDX_W'(cnt_r >> 1);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign rd_word = cell_r[rd_idx];

  // shift cells toward the tail to open a slot, or toward the head to close one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.commit && do_ins) begin
        if (CNT_W'(i) == tgt) cell_nxt[i] = req_val_r;
        else if (i > 0 && CNT_W'(i) > tgt) cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
      end else if (cmd.commit && do_del) begin
        if (i < CAPACITY - 1 && CNT_W'(i) >= tgt)
          cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // adjust the element count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.commit && do_ins) cnt_nxt = cnt_r + CNT_W'(1);
    else if (cmd.commit && do_del) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // hold the result until the downstream transfer
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= st;
      rd_r     <= do_rd ? rd_word : NO_VALUE;
      count_r  <= cnt_nxt;
    end
  end

  assign res_status     = status_r;
  assign res_read_value = rd_r;
  assign res_count      = count_r;

endmodule

/* hw/rtl/ordered_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered list of signed 32-bit words with insert, read and delete
// requests; one result per request.
// ----------------------------------------------------------------------------
// Each request is first captured; then the row of 16 cells compares every
// element against the request value, shifts by one place and writes the
// result register. The next request is accepted in the cycle after the
// result is written, even while that result still waits for its transfer;
// a request is held in its execute step only while the previous result is
// still not taken. No clearing pass follows reset: the list is empty and
// ready at once.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [olist_pkg::IN_DATA_W-1:0]       in_tdata,   // position[7:0], value[39:8]
  input  logic [olist_pkg::KIND_W-1:0]          in_tuser,   // kind[3:0]
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [olist_pkg::OUT_DATA_W-1:0]      out_tdata   // status[2:0], read_value[34:3],
                                                            // count[39:35]
);
  import olist_pkg::*;

  cmd_t                     cmd;
  logic [STAT_W-1:0]        res_status;
  logic signed [WORD_W-1:0] res_read_value;
  logic [CNT_W-1:0]         res_count;

  olist_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  olist_cells u_cells (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_tuser),
    .in_position    (in_tdata[POS_W-1:0]),
    .in_value       (in_tdata[POS_W+WORD_W-1:POS_W]),
    .res_status     (res_status),
    .res_read_value (res_read_value),
    .res_count      (res_count)
  );

  // pack the result fields from the lowest bit up
  assign out_tdata = {res_count, res_read_value, res_status};

endmodule

/* hw/rtl/olist_checker.sv */
// ----------------------------------------------------------------------------
// olist_checker
// Port-level checks of the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
module olist_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [olist_pkg::OUT_DATA_W-1:0] out_tdata
);
  import olist_pkg::*;

  logic [STAT_W-1:0] st;
  logic [WORD_W-1:0] rd;
  logic [CNT_W-1:0]  cnt;

  assign st  = out_tdata[STAT_W-1:0];
  assign rd  = out_tdata[STAT_W+WORD_W-1:STAT_W];
  assign cnt = out_tdata[OUT_DATA_W-1:STAT_W+WORD_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while one is in progress");

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // a failed request reads nothing
  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_OK |-> rd == NO_VALUE)
    else $error("failed request carries a read value");

endmodule

bind ordered_list_engine_unit olist_checker u_olist_checker (.*);
